@@ hdl/modexp_pkg.sv @@
// Package for the modular exponentiation block: word types and sequencer states.
// Used by modular_exponentiation_top, modexp_checker and the testbench. No dependencies.
package modexp_pkg;

  localparam int FieldWidth = 32;

  typedef struct packed {
    logic [FieldWidth-1:0] base;
    logic [FieldWidth-1:0] exponent;
    logic [FieldWidth-1:0] modulus;
  } in_word_t;

  typedef struct packed {
    logic [FieldWidth-1:0] power_mod;
    logic                  bad_modulus;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_PICK,
    ST_MUL_ACC,
    ST_MUL_SQ
  } state_t;

endpackage

@@ hdl/modexp_mulmod.sv @@
// Bit-serial modular multiplier: prod = (a * b) mod m, one bit of b per cycle, MSB first.
// Needs a < m and m != 0; b may be any value. Standalone, no package dependency.
module modexp_mulmod #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [OPERAND_WIDTH-1:0] a,
  input  logic [OPERAND_WIDTH-1:0] b,
  input  logic [OPERAND_WIDTH-1:0] m,
  output logic                     fin,
  output logic [OPERAND_WIDTH-1:0] prod
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);

  logic          run;
  logic [CW-1:0] cnt;
  logic [W-1:0]  acc;
  logic [W-1:0]  aop;
  logic [W-1:0]  bsh;
  logic [W-1:0]  modv;

  logic [W+1:0] sum;
  logic [W+1:0] m1;
  logic [W+1:0] m2;
  logic [W-1:0] acc_next;

  // 2*acc + bit*a stays below 3m, so at most two subtractions of m fold it back
  always_comb begin
    sum = {1'b0, acc, 1'b0} + {2'b00, (bsh[W-1] ? aop : '0)};
    m1  = {2'b00, modv};
    m2  = {1'b0, modv, 1'b0};
    if (sum >= m2) begin
      acc_next = W'(sum - m2);
    end else if (sum >= m1) begin
      acc_next = W'(sum - m1);
    end else begin
      acc_next = W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        run <= 1'b1;
      end else if (run && cnt == '0) begin
        run <= 1'b0;
        fin <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc  <= '0;
      aop  <= a;
      bsh  <= b;
      modv <= m;
      cnt  <= CW'(W - 1);
    end else if (run) begin
      acc <= acc_next;
      bsh <= {bsh[W-2:0], 1'b0};
      cnt <= cnt - CW'(1);
    end
  end

  assign prod = acc;

endmodule

@@ hdl/modular_exponentiation_top.sv @@
// Modular exponentiation, right-to-left binary square-and-multiply.
// Zero modulus or zero exponent is answered from idle, with done high in the next cycle;
//   otherwise a reducing multiply, then one multiply per set exponent bit and one squaring per shift.
//   One word in flight; busy is high while the multiplies run and low again when done rises.
// Throughput is set by the single bit-serial modular multiplier (one multiplier bit per cycle);
//   the next word can be taken in the cycle that done is high.
// Reset (rst, synchronous, active high) returns the sequencer to idle and drops done.
module modular_exponentiation_top #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  modexp_pkg::in_word_t operands,
  output logic                 done,
  output modexp_pkg::out_word_t result
);

  localparam int W = OPERAND_WIDTH;

  modexp_pkg::state_t state;
  modexp_pkg::state_t state_next;

  // Operands reduced to the working width
  logic [W-1:0] in_base;
  logic [W-1:0] in_exp;
  logic [W-1:0] in_mod;
  logic [W-1:0] one_in;     // 1 mod modulus
  logic         accept;

  // Working registers
  logic [W-1:0] acc;        // running product
  logic [W-1:0] sq;         // running square base^(2^k)
  logic [W-1:0] expo;       // exponent bits still to scan
  logic [W-1:0] modv;

  // Multiplier hookup
  logic         mm_go;
  logic [W-1:0] mm_a;
  logic [W-1:0] mm_b;
  logic [W-1:0] mm_m;
  logic         mm_fin;
  logic [W-1:0] mm_prod;

  logic                  done_next;
  modexp_pkg::out_word_t result_next;

  assign in_base = W'(operands.base);
  assign in_exp  = W'(operands.exponent);
  assign in_mod  = W'(operands.modulus);
  assign one_in  = (in_mod == W'(1)) ? '0 : W'(1);
  assign accept  = start && !busy;
  assign busy    = (state != modexp_pkg::ST_IDLE);

  modexp_mulmod #(
    .OPERAND_WIDTH(W)
  ) u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .go   (mm_go),
    .a    (mm_a),
    .b    (mm_b),
    .m    (mm_m),
    .fin  (mm_fin),
    .prod (mm_prod)
  );

  // Sequencer: first pass reduces base mod m (as (1 mod m) * base), then one
  // multiply per set exponent bit and one squaring per shift.
  always_comb begin
    state_next  = state;
    mm_go       = 1'b0;
    mm_a        = sq;
    mm_b        = sq;
    mm_m        = modv;
    done_next   = 1'b0;
    result_next = '{power_mod: '0, bad_modulus: 1'b0};
    unique case (state)
      modexp_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_mod == '0) begin
            // zero modulus: flag it, result zero
            done_next   = 1'b1;
            result_next = '{power_mod: '0, bad_modulus: 1'b1};
          end else if (in_exp == '0) begin
            // x^0 is 1, not reduced (so 1 even for modulus 1)
            done_next   = 1'b1;
            result_next = '{power_mod: modexp_pkg::FieldWidth'(1), bad_modulus: 1'b0};
          end else begin
            mm_go      = 1'b1;
            mm_a       = one_in;
            mm_b       = in_base;
            mm_m       = in_mod;
            state_next = modexp_pkg::ST_REDUCE;
          end
        end
      end
      modexp_pkg::ST_PICK: begin
        if (expo == '0) begin
          done_next   = 1'b1;
          result_next = '{power_mod: modexp_pkg::FieldWidth'(acc), bad_modulus: 1'b0};
          state_next  = modexp_pkg::ST_IDLE;
        end else if (expo[0]) begin
          mm_go      = 1'b1;
          mm_a       = acc;
          mm_b       = sq;
          state_next = modexp_pkg::ST_MUL_ACC;
        end else begin
          mm_go      = 1'b1;
          state_next = modexp_pkg::ST_MUL_SQ;
        end
      end
      modexp_pkg::ST_REDUCE,
      modexp_pkg::ST_MUL_ACC,
      modexp_pkg::ST_MUL_SQ: begin
        if (mm_fin) begin
          state_next = modexp_pkg::ST_PICK;
        end
      end
      default: begin
        state_next = modexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= modexp_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (done_next) begin
      result <= result_next;
    end
    case (state)
      modexp_pkg::ST_IDLE: begin
        if (accept) begin
          modv <= in_mod;
          expo <= in_exp;
          acc  <= one_in;
        end
      end
      modexp_pkg::ST_REDUCE: begin
        if (mm_fin) begin
          sq <= mm_prod;
        end
      end
      modexp_pkg::ST_MUL_ACC: begin
        if (mm_fin) begin
          acc     <= mm_prod;
          expo[0] <= 1'b0;  // bit consumed; a squaring follows unless expo is now zero
        end
      end
      modexp_pkg::ST_MUL_SQ: begin
        if (mm_fin) begin
          sq   <= mm_prod;
          expo <= expo >> 1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/modexp_checker.sv @@
// Port-level checks for modular_exponentiation_top, attached by bind.
// Depends on modexp_pkg for the word types.
module modexp_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input modexp_pkg::in_word_t  operands,
  input logic                  done,
  input modexp_pkg::out_word_t result
);

  a_zero_mod: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operands.modulus == '0)
      |=> (done && result.bad_modulus && result.power_mod == '0))
    else $error("zero modulus not flagged");

  a_zero_exp: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operands.modulus != '0 && operands.exponent == '0)
      |=> (done && !result.bad_modulus && result.power_mod == 32'd1))
    else $error("zero exponent did not give one");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while still busy");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a start");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.bad_modulus) |-> (result.power_mod == '0))
    else $error("error word carries nonzero result");

endmodule

bind modular_exponentiation_top modexp_checker u_modexp_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .operands (operands),
  .done     (done),
  .result   (result)
);

@@ tb/sv/modular_exponentiation_top_tb.sv @@
// Testbench for modular_exponentiation_top: directed and random operand words.
// A scoreboard class predicts each power_mod word. Depends on modexp_pkg.
module modular_exponentiation_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import modexp_pkg::*;

  localparam int OpWidth = 32;
  // No accept on either side for this many cycles ends the run. The slowest
  // legal stretch is a full 32-bit exponent or a long sender gap.
  localparam int StallLimit = 20000;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  // Expected-result store: one word per accepted operand word, in order.
  class power_mod_scoreboard;
    out_word_t expected_words[$];
    int        errors;

    // Square-and-multiply from the low exponent bit. Residues stay under
    // 2^32, so a 64-bit product never overflows.
    static function out_word_t predict_power(in_word_t w);
      bit [63:0] op_mask;
      bit [63:0] b;
      bit [63:0] e;
      bit [63:0] m;
      bit [63:0] acc;
      bit [63:0] sq;
      out_word_t r;
      op_mask = {64{1'b1}} >> (64 - OpWidth);
      b = 64'(w.base) & op_mask;
      e = 64'(w.exponent) & op_mask;
      m = 64'(w.modulus) & op_mask;
      if (m == 0) begin
        r.power_mod   = '0;
        r.bad_modulus = 1'b1;
        return r;
      end
      // zero exponent gives 1 unreduced, even for a modulus of 1
      acc = 64'd1;
      if (e != 0) begin
        acc = 64'd1 % m;
        sq  = b % m;
        while (e != 0) begin
          if (e[0]) acc = (acc * sq) % m;
          sq = (sq * sq) % m;
          e  = e >> 1;
        end
      end
      r.power_mod   = acc[31:0];
      r.bad_modulus = 1'b0;
      return r;
    endfunction

    function void note_operands(in_word_t w);
      expected_words.push_back(predict_power(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: power_mod %h bad_modulus %b",
               got.power_mod, got.bad_modulus);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.power_mod !== want.power_mod) begin
        $error("power_mod: expected %h, got %h", want.power_mod, got.power_mod);
        errors++;
      end
      if (got.bad_modulus !== want.bad_modulus) begin
        $error("bad_modulus: expected %b, got %b", want.bad_modulus, got.bad_modulus);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_words.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_word_t  operands = '0;
  logic      busy;
  logic      done;
  out_word_t result;

  power_mod_scoreboard sb = new();
  int idle_pct = 0;      // chance in 100 that the sender pauses before a word
  int stall_cycles = 0;

  modular_exponentiation_top #(
    .OPERAND_WIDTH(OpWidth)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .done     (done),
    .result   (result)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Monitor: all sampling happens here on the rising edge, so it sees the
  // values from before the edge. A result can land on the same edge that
  // takes the next word, so the check runs before the new word is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_operands(operands);
      if (done || (start && !busy)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("[modular_exponentiation_top] ERROR");
        $finish;
      end
    end
  end

  function automatic in_word_t make_word(logic [31:0] b, logic [31:0] e, logic [31:0] m);
    in_word_t w;
    w.base     = b;
    w.exponent = e;
    w.modulus  = m;
    return w;
  endfunction

  // Random operands. Mostly full-width values so every bit toggles; some
  // short exponents keep the run time down, plus a sprinkle of the edges
  // (zero and unit modulus, zero exponent, all-ones fields).
  function automatic in_word_t random_operands();
    in_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) w.base = '0;
    else if (pick < 14) w.base = AllOnes;
    else if (pick < 30) w.base = $urandom_range(0, 15);
    else w.base = $urandom();

    pick = $urandom_range(0, 99);
    if (pick < 5) w.exponent = '0;
    else if (pick < 8) w.exponent = AllOnes;
    else if (pick < 45) w.exponent = $urandom() >> $urandom_range(20, 31);
    else w.exponent = $urandom();

    pick = $urandom_range(0, 99);
    if (pick < 4) w.modulus = '0;
    else if (pick < 8) w.modulus = 32'd1;
    else if (pick < 14) w.modulus = AllOnes;
    else if (pick < 30) w.modulus = $urandom_range(2, 1000);
    else w.modulus = $urandom();
    return w;
  endfunction

  // Present one word and hold start until the block takes it. An optional
  // pause first; its length is random so it can end in any phase of the
  // block's current exponentiation.
  task automatic send_word(in_word_t w);
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 2500) : $urandom_range(1, 40);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    operands <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    in_word_t directed[$];

    // Edges of every field and each special case: zero modulus with zero and
    // nonzero exponent, zero exponent over a unit modulus, base at or above
    // the modulus, single-bit and all-ones exponents.
    directed.push_back(make_word(32'd2, 32'd10, 32'd1000));
    directed.push_back(make_word(32'd0, 32'd0, 32'd7));
    directed.push_back(make_word(32'd5, 32'd0, 32'd1));
    directed.push_back(make_word(32'd5, 32'd3, 32'd1));
    directed.push_back(make_word(32'd5, 32'd0, 32'd0));
    directed.push_back(make_word(AllOnes, AllOnes, 32'd0));
    directed.push_back(make_word(32'd0, AllOnes, AllOnes));
    directed.push_back(make_word(AllOnes, AllOnes, AllOnes));
    directed.push_back(make_word(AllOnes, AllOnes, 32'hFFFF_FFFE));
    directed.push_back(make_word(32'd1, AllOnes, 32'hFFFF_FFFB));
    directed.push_back(make_word(AllOnes, 32'd1, 32'd2));
    directed.push_back(make_word(32'd123456789, 32'h8000_0000, 32'hFFFF_FFFB));
    directed.push_back(make_word(32'hDEAD_BEEF, 32'hAAAA_AAAA, 32'h5555_5555));
    directed.push_back(make_word(32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA));
    directed.push_back(make_word(32'd3, 32'hFFFF_FFFA, 32'hFFFF_FFFB));
    directed.push_back(make_word(32'd0, 32'd0, AllOnes));
    directed.push_back(make_word(AllOnes, 32'd0, AllOnes));
    directed.push_back(make_word(32'd7, 32'd1, 32'd13));
    directed.push_back(make_word(32'd20, 32'd1, 32'd13));
    directed.push_back(make_word(32'd2, 32'd31, 32'h8000_0000));
    directed.push_back(make_word(32'd2, 32'd63, AllOnes));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 38;
    foreach (directed[i]) send_word(directed[i]);

    // random, with sender pauses
    repeat (100) send_word(random_operands());

    // hold off until the block is drained, then a long burst with no pauses
    start <= 1'b0;
    drain_results();
    idle_pct = 0;
    repeat (80) send_word(random_operands());

    start <= 1'b0;
    drain_results();
    idle_pct = 38;
    repeat (100) send_word(random_operands());

    start <= 1'b0;
    drain_results();
    repeat (40) @(posedge clk);

    if (sb.errors == 0) begin
      $display("[modular_exponentiation_top] OK");
    end else begin
      $display("[modular_exponentiation_top] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/modexp_pkg.sv
hdl/modexp_mulmod.sv
hdl/modular_exponentiation_top.sv
hdl/modexp_checker.sv
tb/sv/modular_exponentiation_top_tb.sv
